/* hw/rtl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants for the slot allocator and pending dispatcher.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int OP_W   = 2;
  localparam int SLOT_W = 5;
  localparam int KIND_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_DRAIN   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOCATED = 2'd0,
    KIND_FULL      = 2'd1,
    KIND_DISPATCH  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              alloc_en;
    logic              rel_en;
    logic              trig_en;
    logic              drain_en;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // Chain running from slot 0 upward.
  typedef struct packed {
    logic              free_seen;
    logic              pend_seen;
    logic [SLOT_W-1:0] alloc_slot;
  } up_t;

  // Chain running from the top slot downward.
  typedef struct packed {
    logic              pend_seen;
    logic [SLOT_W-1:0] drain_slot;
    logic              drain_last;
  } dn_t;

endpackage

/* hw/rtl/sap_req_if.sv */
// ----------------------------------------------------------------------------
// sap_req_if
// Request channel: valid/ready handshake with opcode and slot.
// ----------------------------------------------------------------------------
interface sap_req_if;
  logic                      valid;
  logic                      ready;
  logic [sap_pkg::OP_W-1:0]  opcode;
  logic [sap_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output opcode, output slot, input ready);
  modport sink   (input valid, input opcode, input slot, output ready);
endinterface

/* hw/rtl/sap_rsp_if.sv */
// ----------------------------------------------------------------------------
// sap_rsp_if
// Result channel: valid/ready handshake with kind, slot number and last mark.
// ----------------------------------------------------------------------------
interface sap_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sap_pkg::KIND_W-1:0] kind;
  logic [sap_pkg::SLOT_W-1:0] slot_out;
  logic                       last;

  modport source (output valid, output kind, output slot_out, output last, input ready);
  modport sink   (input valid, input kind, input slot_out, input last, output ready);
endinterface

/* hw/rtl/slot_allocator_pending_dispatcher.sv */
// ----------------------------------------------------------------------------
// slot_allocator_pending_dispatcher
// Free/pending bitmap over a row of slot cells; allocates the lowest free
// slot and drains pending highest first, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   channel   | dir | handshake           | payload
//   ----------+-----+---------------------+-------------------------------
//   in_req    | in  | valid/ready         | opcode[1:0], slot[4:0]
//   out_rsp   | out | valid/ready         | kind[1:0], slot_out[4:0], last
//
// Allocate, release and trigger complete on acceptance; allocate's result
// sits in the output register the cycle after acceptance. A drain with a
// slot pending enters the drain state and gives one pending slot per
// result; each pick is the highest pending cell in the downward chain.
// Requests are held off while a drain runs or while an unread result blocks
// the output register.
// Synchronous active-low reset: every slot free, nothing pending.
//
module slot_allocator_pending_dispatcher #(
  parameter int SLOT_COUNT = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  sap_req_if.sink  in_req,
  sap_rsp_if.source out_rsp
);

  localparam int SW = sap_pkg::SLOT_W;

  sap_pkg::state_t state_r, state_nxt;
  sap_pkg::cmd_t   cmd;
  sap_pkg::up_t    up_c [0:SLOT_COUNT];
  sap_pkg::dn_t    dn_c [0:SLOT_COUNT];

  logic                       out_valid_r, out_valid_nxt;
  logic [sap_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SW-1:0]              out_slot_r, out_slot_nxt;
  logic                       out_last_r, out_last_nxt;

  logic          out_free;
  logic          accept;
  logic          in_range;
  logic          load;
  sap_pkg::op_t  op;

  assign op       = sap_pkg::op_t'(in_req.opcode);
  assign in_range = ({1'b0, in_req.slot} < (SW+1)'(SLOT_COUNT));

  // Output register frees up when empty or being read this cycle.
  assign out_free     = ~out_valid_r | out_rsp.ready;
  assign in_req.ready = (state_r == sap_pkg::ST_IDLE) & out_free;
  assign accept       = in_req.valid & in_req.ready;

  // Decode the accepted request into a command for the cell row.
  always_comb begin
    cmd          = '0;
    cmd.slot     = in_req.slot;
    cmd.drain_en = (state_r == sap_pkg::ST_DRAIN) & out_free;
    case (op)
      sap_pkg::OP_ALLOC:   cmd.alloc_en = accept;
      sap_pkg::OP_RELEASE: cmd.rel_en   = accept & in_range;
      sap_pkg::OP_TRIGGER: cmd.trig_en  = accept & in_range;
      sap_pkg::OP_DRAIN:   cmd.alloc_en = 1'b0;
      default:             cmd.alloc_en = 1'b0;
    endcase
  end

  // Row of slot cells; chains start empty at both ends.
  assign up_c[0]          = '0;
  assign dn_c[SLOT_COUNT] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    sap_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .up_in  (up_c[i]),
      .up_out (up_c[i+1]),
      .dn_in  (dn_c[i+1]),
      .dn_out (dn_c[i])
    );
  end

  // Next state: enter drain only if something is pending, leave on last pick.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sap_pkg::ST_IDLE: begin
        if (accept && op == sap_pkg::OP_DRAIN && dn_c[0].pend_seen) begin
          state_nxt = sap_pkg::ST_DRAIN;
        end
      end
      sap_pkg::ST_DRAIN: begin
        if (cmd.drain_en && dn_c[0].drain_last) begin
          state_nxt = sap_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sap_pkg::ST_IDLE;
    endcase
  end

  // Output register load: allocate result or one dispatched slot.
  always_comb begin
    load          = cmd.alloc_en | cmd.drain_en;
    out_valid_nxt = load ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    if (cmd.alloc_en) begin
      out_kind_nxt = up_c[SLOT_COUNT].free_seen ? sap_pkg::KIND_ALLOCATED
                                                : sap_pkg::KIND_FULL;
      out_slot_nxt = up_c[SLOT_COUNT].alloc_slot;
      out_last_nxt = 1'b1;
    end else if (cmd.drain_en) begin
      out_kind_nxt = sap_pkg::KIND_DISPATCH;
      out_slot_nxt = dn_c[0].drain_slot;
      out_last_nxt = dn_c[0].drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sap_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.kind     = out_kind_r;
  assign out_rsp.slot_out = out_slot_r;
  assign out_rsp.last     = out_last_r;

endmodule

/* hw/rtl/sap_cell.sv */
// ----------------------------------------------------------------------------
// sap_cell
// One slot: free and pending bits, plus its links in the search chains.
// ----------------------------------------------------------------------------
module sap_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sap_pkg::cmd_t cmd,
  input  sap_pkg::up_t  up_in,
  output sap_pkg::up_t  up_out,
  input  sap_pkg::dn_t  dn_in,
  output sap_pkg::dn_t  dn_out
);

  localparam logic [sap_pkg::SLOT_W-1:0] MY_SLOT = sap_pkg::SLOT_W'(IDX);

  logic free_r, free_nxt;
  logic pend_r, pend_nxt;
  logic match;
  logic alloc_hit;
  logic drain_hit;

  assign match     = (cmd.slot == MY_SLOT);
  assign alloc_hit = free_r & ~up_in.free_seen;
  assign drain_hit = pend_r & ~dn_in.pend_seen;

  // Lowest free slot wins going up; highest pending slot wins going down.
  always_comb begin
    up_out.free_seen  = up_in.free_seen | free_r;
    up_out.pend_seen  = up_in.pend_seen | pend_r;
    up_out.alloc_slot = up_in.alloc_slot | (alloc_hit ? MY_SLOT : '0);
    dn_out.pend_seen  = dn_in.pend_seen | pend_r;
    dn_out.drain_slot = dn_in.drain_slot | (drain_hit ? MY_SLOT : '0);
    // last when nothing pending below the winner
    dn_out.drain_last = dn_in.drain_last | (drain_hit & ~up_in.pend_seen);
  end

  always_comb begin
    free_nxt = free_r;
    pend_nxt = pend_r;
    if (cmd.rel_en && match) begin
      free_nxt = 1'b1;
      pend_nxt = 1'b0;
    end
    if (cmd.alloc_en && alloc_hit) begin
      free_nxt = 1'b0;
    end
    if (cmd.trig_en && match) begin
      pend_nxt = 1'b1;
    end
    if (cmd.drain_en && drain_hit) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b1;
      pend_r <= 1'b0;
    end else begin
      free_r <= free_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

/* hw/rtl/sap_checker.sv */
// ----------------------------------------------------------------------------
// sap_checker
// Port-level checks on the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sap_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [sap_pkg::OP_W-1:0]   in_opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sap_pkg::KIND_W-1:0] out_kind,
  input logic [sap_pkg::SLOT_W-1:0] out_slot_out,
  input logic                       out_last
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Allocate answers in the next cycle with a single, last result.
  a_alloc_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == sap_pkg::OP_ALLOC
    |=> out_valid && out_last &&
        (out_kind == sap_pkg::KIND_ALLOCATED || out_kind == sap_pkg::KIND_FULL))
    else $error("allocate did not answer next cycle");

  // Release and trigger give no result.
  a_quiet_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_opcode == sap_pkg::OP_RELEASE || in_opcode == sap_pkg::OP_TRIGGER)
    |=> !out_valid)
    else $error("release or trigger produced a result");

  // Hold off requests while a drain still has results to give.
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == sap_pkg::KIND_DISPATCH && !out_last
    |-> !in_ready)
    else $error("request taken mid-drain");

  // No free slot reports slot zero.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sap_pkg::KIND_FULL |-> out_slot_out == '0)
    else $error("full result with nonzero slot");

endmodule

bind slot_allocator_pending_dispatcher sap_checker u_sap_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .in_opcode    (in_req.opcode),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_kind     (out_rsp.kind),
  .out_slot_out (out_rsp.slot_out),
  .out_last     (out_rsp.last)
);
